### hdl/avcflv_pkg.sv
package avcflv_pkg;

  // SPS store geometry
  localparam int SPS_MAX_BYTES = 32;
  localparam int SPS_ADDR_W    = $clog2(SPS_MAX_BYTES);
  localparam int SPS_LEN_W     = $clog2(SPS_MAX_BYTES + 1);

  // NAL unit types
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  // Fixed bytes of the tag body
  localparam logic [7:0] BYTE_KEY   = 8'h17;
  localparam logic [7:0] BYTE_INTER = 8'h27;
  localparam logic [7:0] BYTE_ONE   = 8'h01;
  localparam logic [7:0] BYTE_FF    = 8'hFF;
  localparam logic [7:0] BYTE_E1    = 8'hE1;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;

  // Microprogram layout
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] REC_ENTRY  = 5'd0;
  localparam logic [STEP_W-1:0] SPS_LOOP   = 5'd13;
  localparam logic [STEP_W-1:0] AFTER_LOOP = 5'd14;
  localparam logic [STEP_W-1:0] HDR_ENTRY  = 5'd17;

  // What one accepted input item starts
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PASS,
    ACT_RECORD,
    ACT_HEADER
  } act_t;

  // Byte source of a control word
  typedef enum logic [3:0] {
    SRC_CONST,
    SRC_STORE,
    SRC_KIND,
    SRC_SPSLEN,
    SRC_PLEN_HI,
    SRC_PLEN_LO,
    SRC_LEN2,
    SRC_LEN1,
    SRC_LEN0
  } src_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_ZERO
  } ptr_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_IF_EMPTY,
    JMP_LOOP,
    JMP_END
  } jmp_t;

  typedef enum logic [1:0] {
    EOP_NONE,
    EOP_PLEN,
    EOP_LEN
  } eop_t;

  typedef struct packed {
    src_t              src;
    ptr_t              ptr;
    jmp_t              jmp;
    eop_t              eop;
    logic              pkind;
    logic [7:0]        value;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Command from the input decoder to the sequencer
  typedef struct packed {
    act_t        act;
    logic [7:0]  data;
    logic        pkind;
    logic        eop;
    logic        idr;
    logic [23:0] hdr_len;
    logic [15:0] plen;
    logic        plen_last;
  } seq_cmd_t;

  // SPS store status
  typedef struct packed {
    logic [SPS_LEN_W-1:0] len;
    logic                 ovf;
  } sps_stat_t;

  // Control store: record program first, then the frame header program
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      5'd0:  w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_KEY,  '0};
      5'd1:  w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ZERO, '0};
      5'd2:  w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ZERO, '0};
      5'd3:  w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ZERO, '0};
      5'd4:  w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ZERO, '0};
      5'd5:  w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ONE,  '0};
      5'd6:  w = '{SRC_STORE,   PTR_INC,  JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ZERO, '0};
      5'd7:  w = '{SRC_STORE,   PTR_INC,  JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ZERO, '0};
      5'd8:  w = '{SRC_STORE,   PTR_ZERO, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ZERO, '0};
      5'd9:  w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_FF,   '0};
      5'd10: w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_E1,   '0};
      5'd11: w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ZERO, '0};
      5'd12: w = '{SRC_SPSLEN,  PTR_HOLD, JMP_IF_EMPTY, EOP_NONE, 1'b0, BYTE_ZERO,
                   AFTER_LOOP};
      5'd13: w = '{SRC_STORE,   PTR_INC,  JMP_LOOP,     EOP_NONE, 1'b0, BYTE_ZERO,
                   SPS_LOOP};
      5'd14: w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ONE,  '0};
      5'd15: w = '{SRC_PLEN_HI, PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b0, BYTE_ZERO, '0};
      5'd16: w = '{SRC_PLEN_LO, PTR_HOLD, JMP_END,      EOP_PLEN, 1'b0, BYTE_ZERO, '0};
      5'd17: w = '{SRC_KIND,    PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b1, BYTE_ZERO, '0};
      5'd18: w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b1, BYTE_ONE,  '0};
      5'd19: w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b1, BYTE_ZERO, '0};
      5'd20: w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b1, BYTE_ZERO, '0};
      5'd21: w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b1, BYTE_ZERO, '0};
      5'd22: w = '{SRC_CONST,   PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b1, BYTE_ZERO, '0};
      5'd23: w = '{SRC_LEN2,    PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b1, BYTE_ZERO, '0};
      5'd24: w = '{SRC_LEN1,    PTR_HOLD, JMP_NEXT,     EOP_NONE, 1'b1, BYTE_ZERO, '0};
      5'd25: w = '{SRC_LEN0,    PTR_HOLD, JMP_END,      EOP_LEN,  1'b1, BYTE_ZERO, '0};
      default: w = '{SRC_CONST, PTR_HOLD, JMP_END,      EOP_NONE, 1'b1, BYTE_ZERO, '0};
    endcase
    return w;
  endfunction

endpackage

### hdl/avcflv_ram.sv
module avcflv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/avcflv_front.sv
module avcflv_front import avcflv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            nal_byte,
  input  logic [4:0]            nal_kind,
  input  logic [23:0]           nal_total_length,
  input  logic                  is_first_byte,
  input  logic                  accept,
  output seq_cmd_t              cmd,
  output sps_stat_t             sps,
  output logic                  wr_en,
  output logic [SPS_ADDR_W-1:0] wr_addr,
  output logic [7:0]            wr_data
);

  logic [23:0]          byte_position;
  logic                 long_start_code;
  logic [SPS_LEN_W-1:0] sps_length;
  logic                 sps_overflow;

  logic [23:0]          p;
  logic [SPS_LEN_W-1:0] len_eff;
  logic [23:0]          start_cur;
  logic [23:0]          start_new;
  logic                 is_hdr;
  logic                 sps_room;

  // Decode the item against the NAL position
  always_comb begin
    p         = is_first_byte ? '0 : byte_position;
    len_eff   = is_first_byte ? '0 : sps_length;
    sps_room  = len_eff < SPS_LEN_W'(SPS_MAX_BYTES);
    start_cur = long_start_code ? 24'd4 : 24'd3;
    start_new = (nal_byte == BYTE_ZERO) ? 24'd4 : 24'd3;
    is_hdr    = 1'b0;

    cmd.act       = ACT_NONE;
    cmd.data      = nal_byte;
    cmd.pkind     = 1'b1;
    cmd.eop       = (p == nal_total_length - 24'd1);
    cmd.idr       = (nal_kind == NAL_IDR);
    cmd.hdr_len   = (nal_total_length > start_new) ? nal_total_length - start_new : '0;
    cmd.plen      = nal_total_length[15:0] - 16'd4;
    cmd.plen_last = (nal_total_length == 24'd4);

    case (nal_kind)
      NAL_SPS: begin
        cmd.act = ACT_NONE;
      end
      NAL_PPS: begin
        cmd.pkind = 1'b0;
        if (p == 24'd3 && nal_total_length >= 24'd4) begin
          cmd.act = ACT_RECORD;
        end else if (p >= 24'd4 && p < nal_total_length) begin
          cmd.act = ACT_PASS;
        end
      end
      default: begin
        if (p == 24'd2 && nal_total_length > 24'd2) begin
          cmd.act = ACT_HEADER;
          is_hdr  = 1'b1;
        end else if (p >= start_cur && p < nal_total_length) begin
          cmd.act = ACT_PASS;
        end
      end
    endcase

    wr_en   = accept && (nal_kind == NAL_SPS) && (p >= 24'd4) && sps_room;
    wr_addr = len_eff[SPS_ADDR_W-1:0];
    wr_data = nal_byte;

    sps.len = sps_length;
    sps.ovf = sps_overflow;
  end

  // Advance position, track start code form and SPS fill
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      long_start_code <= 1'b0;
      sps_length      <= '0;
      sps_overflow    <= 1'b0;
    end else if (accept) begin
      byte_position <= (p < 24'hFFFFFF) ? p + 24'd1 : p;
      if (is_hdr) begin
        long_start_code <= (nal_byte == BYTE_ZERO);
      end
      if (nal_kind == NAL_SPS) begin
        if (is_first_byte) begin
          sps_length   <= '0;
          sps_overflow <= 1'b0;
        end
        if (p >= 24'd4) begin
          if (sps_room) begin
            sps_length <= len_eff + 1'b1;
          end else begin
            sps_overflow <= 1'b1;
          end
        end
      end
    end
  end

endmodule

### hdl/avcflv_seq.sv
module avcflv_seq import avcflv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  seq_cmd_t              cmd,
  input  sps_stat_t             sps,
  output logic [SPS_ADDR_W-1:0] rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  avail,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  packet_kind,
  output logic                  end_of_packet,
  output logic                  end_of_run,
  output logic                  sps_truncated
);

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic [SPS_LEN_W-1:0] rptr;
  logic                 idr;
  logic [23:0]          hdr_len;
  logic [15:0]          plen;
  logic                 plen_last;

  logic                 busy_next;
  logic [STEP_W-1:0]    step_next;
  logic [SPS_LEN_W-1:0] rptr_next;
  logic [SPS_LEN_W-1:0] rptr_inc;
  ucode_t               w;
  logic                 load;
  logic                 pass;
  logic                 begin_prog;
  logic [7:0]           mux;
  logic                 eop;

  // Decode the current control word and step the program
  always_comb begin
    w          = ucode_rom(step);
    load       = busy && (!out_valid || out_ready);
    avail      = !busy && (!out_valid || out_ready);
    pass       = start && (cmd.act == ACT_PASS);
    begin_prog = start && (cmd.act == ACT_RECORD || cmd.act == ACT_HEADER);
    rptr_inc   = rptr + 1'b1;

    case (w.src)
      SRC_CONST:   mux = w.value;
      SRC_STORE:   mux = rd_data;
      SRC_KIND:    mux = idr ? BYTE_KEY : BYTE_INTER;
      SRC_SPSLEN:  mux = 8'(sps.len);
      SRC_PLEN_HI: mux = plen[15:8];
      SRC_PLEN_LO: mux = plen[7:0];
      SRC_LEN2:    mux = hdr_len[23:16];
      SRC_LEN1:    mux = hdr_len[15:8];
      SRC_LEN0:    mux = hdr_len[7:0];
      default:     mux = w.value;
    endcase

    case (w.eop)
      EOP_PLEN: eop = plen_last;
      EOP_LEN:  eop = (hdr_len == '0);
      default:  eop = 1'b0;
    endcase

    busy_next = busy;
    step_next = step;
    rptr_next = rptr;

    if (begin_prog) begin
      busy_next = 1'b1;
      step_next = (cmd.act == ACT_RECORD) ? REC_ENTRY : HDR_ENTRY;
      rptr_next = SPS_LEN_W'(1);
    end else if (load) begin
      case (w.ptr)
        PTR_INC:  rptr_next = rptr_inc;
        PTR_ZERO: rptr_next = '0;
        default:  rptr_next = rptr;
      endcase
      case (w.jmp)
        JMP_IF_EMPTY: step_next = (sps.len == '0) ? w.target : step + 1'b1;
        JMP_LOOP:     step_next = (rptr_inc != sps.len) ? w.target : step + 1'b1;
        JMP_END:      busy_next = 1'b0;
        default:      step_next = step + 1'b1;
      endcase
    end

    // Read ahead so the store byte is ready when its step loads
    rd_addr = rptr_next[SPS_ADDR_W-1:0];
  end

  // Sequencer control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      rptr <= '0;
    end else begin
      busy <= busy_next;
      step <= step_next;
      rptr <= rptr_next;
    end
  end

  // Latch per-program operands
  always_ff @(posedge clk) begin
    if (begin_prog) begin
      idr       <= cmd.idr;
      hdr_len   <= cmd.hdr_len;
      plen      <= cmd.plen;
      plen_last <= cmd.plen_last;
    end
  end

  // Output register: take a program byte or a passed-through NAL byte
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load || pass) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= mux;
      packet_kind   <= w.pkind;
      end_of_packet <= eop;
      end_of_run    <= (w.jmp == JMP_END);
      sps_truncated <= sps.ovf;
    end else if (pass) begin
      out_byte      <= cmd.data;
      packet_kind   <= cmd.pkind;
      end_of_packet <= cmd.eop;
      end_of_run    <= 1'b1;
      sps_truncated <= sps.ovf;
    end
  end

endmodule

### hdl/avc_nal_to_flv_video_tag.sv
// Channel  Handshake            Payload
// -------  -------------------  -------------------------------------------------
// in       in_valid / in_ready  nal_byte, nal_kind, nal_total_length, is_first_byte
// out      out_valid/out_ready  out_byte, packet_kind, end_of_packet, end_of_run,
//                               sps_truncated
//
// A byte that is stored or passed through goes at a full byte per cycle when the output is not stalled.
// A frame header holds the input for 9 output bytes; a decoder configuration record
// holds it for 16 + SPS length bytes, paced by the microcode step counter and the
// single read port of the SPS store.
// Synchronous reset clears position, start code form, SPS fill and the sequencer.
// A stalled output freezes the sequencer and blocks new items.
module avc_nal_to_flv_video_tag import avcflv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  nal_byte,
  input  logic [4:0]  nal_kind,
  input  logic [23:0] nal_total_length,
  input  logic        is_first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        packet_kind,
  output logic        end_of_packet,
  output logic        end_of_run,
  output logic        sps_truncated
);

  logic                  accept;
  seq_cmd_t              cmd;
  sps_stat_t             sps;
  logic                  wr_en;
  logic [SPS_ADDR_W-1:0] wr_addr;
  logic [7:0]            wr_data;
  logic [SPS_ADDR_W-1:0] rd_addr;
  logic [7:0]            rd_data;
  logic                  avail;

  assign in_ready = avail;
  assign accept   = in_valid && avail;

  avcflv_front u_front (
    .clk,
    .rst,
    .nal_byte,
    .nal_kind,
    .nal_total_length,
    .is_first_byte,
    .accept,
    .cmd,
    .sps,
    .wr_en,
    .wr_addr,
    .wr_data
  );

  avcflv_ram #(
    .WIDTH(8),
    .DEPTH(SPS_MAX_BYTES)
  ) u_sps_store (
    .clk,
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  avcflv_seq u_seq (
    .clk,
    .rst,
    .start (accept),
    .cmd,
    .sps,
    .rd_addr,
    .rd_data,
    .avail,
    .out_valid,
    .out_ready,
    .out_byte,
    .packet_kind,
    .end_of_packet,
    .end_of_run,
    .sps_truncated
  );

endmodule

### hdl/avcflv_chk.sv
module avcflv_chk import avcflv_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [4:0]  nal_kind,
  input logic        is_first_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        packet_kind,
  input logic        end_of_packet,
  input logic        end_of_run,
  input logic        sps_truncated
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(packet_kind) &&
      $stable(end_of_packet) && $stable(end_of_run) && $stable(sps_truncated))
    else $error("stalled result item changed");

  // No new item while a result waits on a stalled output
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // No new item while a run of results is still going
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_run |-> !in_ready)
    else $error("input taken in the middle of a run");

  // SPS bytes and first bytes produce nothing
  a_silent_items: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (nal_kind == NAL_SPS || is_first_byte) |=> !out_valid)
    else $error("result from an item that yields none");

endmodule

bind avc_nal_to_flv_video_tag avcflv_chk u_chk (.*);
